// ===== design/ilt_pkg.sv =====
// Shared constants, codes and request/result types for the indexed list table.
package ilt_pkg;

   localparam int DEPTH      = 256;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POS_W      = 9;
   localparam int STEP_W     = 9;
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;

   localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd5;
   localparam logic [MODE_W-1:0] MODE_KTH    = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_STEP = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]            mode;
      logic [POS_W-1:0]             position;
      logic signed [DATA_WIDTH-1:0] value;
      logic [STEP_W-1:0]            step;
   } ilt_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]          status;
      logic signed [DATA_WIDTH-1:0] value_out;
      logic                         found;
      logic [ADDR_W-1:0]            found_index;
      logic [CNT_W-1:0]             count;
      logic                         empty_res;
      logic [CNT_W-1:0]             removed_count;
   } ilt_res_type;

endpackage

// ===== design/ilt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ilt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ilt_engine.sv =====
// Request sequencer: walks the element memory one entry per cycle and commits the count.
module ilt_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ilt_pkg::ilt_req_type req,
   output logic                 idle,
   output logic                 done,
   input  logic                 res_ready,
   output ilt_pkg::ilt_res_type res
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam int AW = ilt_pkg::ADDR_W;
   localparam int CW = ilt_pkg::CNT_W;
   localparam int DW = ilt_pkg::DATA_WIDTH;

   logic [1:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] left_ff, left_in;
   logic up_ff, up_in;
   logic pv_ff, pv_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic [ilt_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [ilt_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [DW-1:0] val_ff, val_in;
   logic [ilt_pkg::STEP_W-1:0] step_ff, step_in;
   logic [ilt_pkg::STEP_W-1:0] phase_ff, phase_in;
   logic [CW-1:0] wptr_ff, wptr_in;
   logic [ilt_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [DW-1:0] vout_ff, vout_in;
   logic found_ff, found_in;
   logic [AW-1:0] fidx_ff, fidx_in;
   logic [CW-1:0] removed_ff, removed_in;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic rd_en;
   logic [DW-1:0] rd_data;

   ilt_ram #(.WIDTH(DW), .DEPTH(ilt_pkg::DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_in      = rd_ff;
      left_in    = left_ff;
      up_in      = up_ff;
      pv_in      = 1'b0;
      pidx_in    = rd_ff[AW-1:0];
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      step_in    = step_ff;
      phase_in   = phase_ff;
      wptr_in    = wptr_ff;
      status_in  = status_ff;
      vout_in    = vout_ff;
      found_in   = found_ff;
      fidx_in    = fidx_ff;
      removed_in = removed_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      done       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in    = req.mode;
               pos_in     = req.position;
               val_in     = req.value;
               step_in    = req.step;
               status_in  = ilt_pkg::ST_OK;
               vout_in    = '0;
               found_in   = 1'b0;
               fidx_in    = '0;
               removed_in = '0;
               phase_in   = '0;
               wptr_in    = '0;
               rd_in      = '0;
               left_in    = '0;
               up_in      = 1'b1;
               state_in   = S_DONE;
               unique case (req.mode)
                  ilt_pkg::MODE_GET, ilt_pkg::MODE_SET: begin
                     if (req.position >= count_ff) begin
                        status_in = ilt_pkg::ST_BAD_POS;
                     end else begin
                        rd_in    = req.position;
                        left_in  = CW'(1);
                        state_in = S_SCAN;
                     end
                  end
                  ilt_pkg::MODE_APPEND: begin
                     if (count_ff >= CW'(ilt_pkg::DEPTH)) begin
                        status_in = ilt_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ilt_pkg::MODE_INSERT: begin
                     if (req.position > count_ff) begin
                        status_in = ilt_pkg::ST_BAD_POS;
                     end else if (count_ff >= CW'(ilt_pkg::DEPTH)) begin
                        status_in = ilt_pkg::ST_FULL;
                     end else begin
                        rd_in    = count_ff - CW'(1);
                        left_in  = count_ff - req.position;
                        up_in    = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  ilt_pkg::MODE_REMOVE: begin
                     if (req.position >= count_ff) begin
                        status_in = ilt_pkg::ST_BAD_POS;
                     end else begin
                        rd_in    = req.position;
                        left_in  = count_ff - req.position;
                        state_in = S_SCAN;
                     end
                  end
                  ilt_pkg::MODE_SEARCH: begin
                     left_in  = count_ff;
                     state_in = S_SCAN;
                  end
                  ilt_pkg::MODE_KTH: begin
                     if (req.step == '0) begin
                        status_in = ilt_pkg::ST_BAD_STEP;
                     end else begin
                        left_in  = count_ff;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue one read per cycle, consume the one issued last cycle
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               pv_in   = 1'b1;
               left_in = left_ff - CW'(1);
               rd_in   = up_ff ? rd_ff + CW'(1) : rd_ff - CW'(1);
            end
            if (pv_ff) begin
               case (mode_ff)
                  ilt_pkg::MODE_GET: begin
                     vout_in = rd_data;
                  end
                  ilt_pkg::MODE_SET: begin
                     vout_in = rd_data;
                     wr_en   = 1'b1;
                     wr_addr = pidx_ff;
                     wr_data = val_ff;
                  end
                  ilt_pkg::MODE_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = pidx_ff + AW'(1);
                     wr_data = rd_data;
                  end
                  ilt_pkg::MODE_REMOVE: begin
                     if (pidx_ff == pos_ff[AW-1:0]) begin
                        vout_in = rd_data;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pidx_ff - AW'(1);
                        wr_data = rd_data;
                     end
                  end
                  ilt_pkg::MODE_SEARCH: begin
                     if (!found_ff && rd_data == val_ff) begin
                        found_in = 1'b1;
                        fidx_in  = pidx_ff;
                        left_in  = '0;
                     end
                  end
                  ilt_pkg::MODE_KTH: begin
                     if (phase_ff == step_ff - ilt_pkg::STEP_W'(1)) begin
                        removed_in = removed_ff + CW'(1);
                        phase_in   = '0;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = wptr_ff[AW-1:0];
                        wr_data  = rd_data;
                        wptr_in  = wptr_ff + CW'(1);
                        phase_in = phase_ff + ilt_pkg::STEP_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (left_ff == '0 && !pv_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            case (mode_ff)
               ilt_pkg::MODE_INSERT: begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff[AW-1:0];
                  wr_data  = val_ff;
                  count_in = count_ff + CW'(1);
               end
               ilt_pkg::MODE_REMOVE: begin
                  count_in = count_ff - CW'(1);
               end
               ilt_pkg::MODE_KTH: begin
                  count_in = wptr_ff;
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end
         S_DONE: begin
            done = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         left_ff  <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         pv_ff    <= pv_in;
      end
      rd_ff      <= rd_in;
      up_ff      <= up_in;
      pidx_ff    <= pidx_in;
      mode_ff    <= mode_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      step_ff    <= step_in;
      phase_ff   <= phase_in;
      wptr_ff    <= wptr_in;
      status_ff  <= status_in;
      vout_ff    <= vout_in;
      found_ff   <= found_in;
      fidx_ff    <= fidx_in;
      removed_ff <= removed_in;
   end

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      res.status        = status_ff;
      res.value_out     = vout_ff;
      res.found         = found_ff;
      res.found_index   = fidx_ff;
      res.count         = count_ff;
      res.empty_res     = (count_ff == '0);
      res.removed_count = removed_ff;
   end

endmodule

// ===== design/indexed_list_table.sv =====
// Top level of the indexed list table: stream handshake, sequencer and result register.
// Append, error and unused-mode requests finish without a memory walk; get/set walk one
// entry, insert/remove count-position, search up to count (stops on a match), k-th count.
// The sequencer takes a new request only when idle, after the current walk has finished.
// A new request is taken while an earlier response still waits in the output register.
// Reset (synchronous, active high) empties the list; element memory is not cleared.
module indexed_list_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // position[8:0], value[40:9], step[49:41], zero pad
   input  logic [2:0]  req_tuser,  // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value_out[31:0], found[32], found_index[40:33], count[49:41],
   // empty_res[50], removed_count[59:51], zero pad
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   ilt_pkg::ilt_req_type req;
   ilt_pkg::ilt_res_type eng_res;
   ilt_pkg::ilt_res_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic eng_idle;
   logic eng_done;
   logic slot_free;
   logic start;

   // unpack the request
   always_comb begin
      req.mode     = req_tuser;
      req.position = req_tdata[8:0];
      req.value    = req_tdata[40:9];
      req.step     = req_tdata[49:41];
   end

   // take a request whenever the sequencer is idle
   assign req_tready = eng_idle;
   assign start      = req_tvalid && eng_idle;

   // output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   ilt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .idle      (eng_idle),
      .done      (eng_done),
      .res_ready (slot_free),
      .res       (eng_res)
   );

   // load a finished response, drop it once taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (eng_done && slot_free) begin
         rsp_in       = eng_res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {4'b0000, rsp_ff.removed_count, rsp_ff.empty_res, rsp_ff.count,
                        rsp_ff.found_index, rsp_ff.found, rsp_ff.value_out};

endmodule
